### hw/rtl/vcsp_pkg.sv
`timescale 1ns / 1ps
// vcsp_pkg: shared types and constants for the voxel chunk stream parser
// used by vcsp_parser, vcsp_result_queue, the top level and its checker

package vcsp_pkg;

  // little-endian tags as seen in a 32-bit word
  localparam logic [31:0] TAG_VOX  = 32'h2058_4F56;
  localparam logic [31:0] TAG_MAIN = 32'h4E49_414D;
  localparam logic [31:0] TAG_SIZE = 32'h455A_4953;
  localparam logic [31:0] TAG_XYZI = 32'h495A_5958;
  localparam logic [31:0] TAG_RGBA = 32'h4142_4752;

  localparam logic [4:0] HEADER_BYTES   = 5'd20;
  localparam logic [4:0] MAGIC_END      = 5'd4;
  localparam logic [4:0] MAIN_END       = 5'd12;
  localparam logic [4:0] MIN_FILE_BYTES = 5'd12;

  // result kinds
  localparam logic [1:0] KIND_VOXEL   = 2'd0;
  localparam logic [1:0] KIND_PALETTE = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // error codes
  localparam logic [1:0] ERR_TOO_SMALL    = 2'd0;
  localparam logic [1:0] ERR_BAD_MAGIC    = 2'd1;
  localparam logic [1:0] ERR_MISSING_MAIN = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] first_value;
    logic [31:0] second_value;
    logic [31:0] third_value;
    logic [31:0] fourth_value;
    logic [1:0]  error_code;
    logic        final_of_input;
  } result_t;

  // results caused by one byte: an item, then a done or error report
  typedef struct packed {
    logic    item_valid;
    result_t item;
    logic    report_valid;
    result_t report;
  } parse_out_t;

endpackage

### hw/rtl/vcsp_parser.sv
`timescale 1ns / 1ps
// vcsp_parser: byte-wise header and chunk walker with all parse state
// depends on vcsp_pkg

module vcsp_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 end_of_file,
  output vcsp_pkg::parse_out_t results
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_CHUNK  = 3'd1,
    PH_SIZE   = 3'd2,
    PH_COUNT  = 3'd3,
    PH_VOXEL  = 3'd4,
    PH_RGBA   = 3'd5,
    PH_SKIP   = 3'd6,
    PH_HALT   = 3'd7
  } phase_t;

  phase_t      phase, phase_next;
  logic [4:0]  hdr_seen, hdr_seen_next;
  logic        magic_failed, magic_failed_next;
  logic        main_failed, main_failed_next;
  logic [31:0] tag_shift, tag_shift_next;
  logic [31:0] word_shift, word_shift_next;
  logic [1:0]  byte_in_word, byte_in_word_next;
  logic [1:0]  word_in_group, word_in_group_next;
  logic [31:0] content_length, content_length_next;
  logic [31:0] content_consumed, content_consumed_next;
  logic [31:0] voxels_left, voxels_left_next;
  logic [8:0]  palette_slot, palette_slot_next;
  logic [31:0] voxel_total, voxel_total_next;
  logic [31:0] size_words [3];
  logic [31:0] size_words_next [3];

  always_comb begin
    logic       word_done;
    logic [31:0] w;
    logic [1:0] size_idx;
    logic       finish;

    phase_next            = phase;
    hdr_seen_next         = hdr_seen;
    magic_failed_next     = magic_failed;
    main_failed_next      = main_failed;
    tag_shift_next        = tag_shift;
    word_shift_next       = word_shift;
    byte_in_word_next     = byte_in_word;
    word_in_group_next    = word_in_group;
    content_length_next   = content_length;
    content_consumed_next = content_consumed;
    voxels_left_next      = voxels_left;
    palette_slot_next     = palette_slot;
    voxel_total_next      = voxel_total;
    size_words_next       = size_words;
    results               = '0;
    word_done             = 1'b0;
    finish                = 1'b0;
    size_idx              = (word_in_group == 2'd3) ? 2'd2 : word_in_group;

    if (hdr_seen < vcsp_pkg::HEADER_BYTES) begin
      hdr_seen_next = hdr_seen + 5'd1;
    end

    if (phase != PH_HALT && phase != PH_SKIP) begin
      word_shift_next   = {data_byte, word_shift[31:8]};
      byte_in_word_next = byte_in_word + 2'd1;
      word_done         = (byte_in_word == 2'd3);
    end
    if (phase >= PH_SIZE && phase <= PH_SKIP && content_consumed != '1) begin
      content_consumed_next = content_consumed + 32'd1;
    end
    w = word_shift_next;

    case (phase)
      PH_HEADER: begin
        if (hdr_seen_next == vcsp_pkg::MAGIC_END && w != vcsp_pkg::TAG_VOX) begin
          magic_failed_next = 1'b1;
          phase_next        = PH_HALT;
        end else if (hdr_seen_next == vcsp_pkg::MAIN_END && w != vcsp_pkg::TAG_MAIN) begin
          main_failed_next = 1'b1;
          phase_next       = PH_HALT;
        end else if (hdr_seen_next == vcsp_pkg::HEADER_BYTES) begin
          phase_next         = PH_CHUNK;
          byte_in_word_next  = 2'd0;
          word_in_group_next = 2'd0;
        end
      end
      PH_CHUNK: begin
        if (word_done) begin
          if (word_in_group == 2'd0) begin
            tag_shift_next     = w;
            word_in_group_next = 2'd1;
          end else if (word_in_group == 2'd1) begin
            content_length_next = w;
            word_in_group_next  = 2'd2;
          end else begin
            word_in_group_next    = 2'd0;
            content_consumed_next = '0;
            if (tag_shift == vcsp_pkg::TAG_SIZE) begin
              size_words_next[0] = '0;
              size_words_next[1] = '0;
              size_words_next[2] = '0;
              phase_next         = PH_SIZE;
            end else if (tag_shift == vcsp_pkg::TAG_XYZI) begin
              phase_next = PH_COUNT;
            end else if (tag_shift == vcsp_pkg::TAG_RGBA) begin
              palette_slot_next = '0;
              phase_next        = PH_RGBA;
            end else begin
              phase_next = (content_length != '0) ? PH_SKIP : PH_CHUNK;
            end
          end
        end
      end
      PH_SIZE: begin
        if (word_done) begin
          size_words_next[size_idx] = w;
          if (word_in_group >= 2'd2) begin
            finish = 1'b1;
          end else begin
            word_in_group_next = word_in_group + 2'd1;
          end
        end
      end
      PH_COUNT: begin
        if (word_done) begin
          voxels_left_next = w;
          if (w == '0) begin
            finish = 1'b1;
          end else begin
            phase_next = PH_VOXEL;
          end
        end
      end
      PH_VOXEL: begin
        if (word_done) begin
          results.item_valid        = 1'b1;
          results.item.kind         = vcsp_pkg::KIND_VOXEL;
          results.item.first_value  = {24'd0, w[7:0]};
          results.item.second_value = {24'd0, w[15:8]};
          results.item.third_value  = {24'd0, w[23:16]};
          results.item.fourth_value = (w[31:24] == 8'd0) ? 32'd1 : {24'd0, w[31:24]};
          voxel_total_next = voxel_total + 32'd1;
          voxels_left_next = voxels_left - 32'd1;
          if (voxels_left_next == '0) begin
            finish = 1'b1;
          end
        end
      end
      PH_RGBA: begin
        if (word_done) begin
          results.item_valid        = 1'b1;
          results.item.kind         = vcsp_pkg::KIND_PALETTE;
          results.item.first_value  = {23'd0, palette_slot};
          results.item.second_value = w;
          palette_slot_next = palette_slot + 9'd1;
          // slot count reached the palette size
          if (palette_slot_next[8]) begin
            finish = 1'b1;
          end
        end
      end
      PH_SKIP: begin
        if (content_consumed_next >= content_length) begin
          phase_next         = PH_CHUNK;
          byte_in_word_next  = 2'd0;
          word_in_group_next = 2'd0;
        end
      end
      default: begin
      end
    endcase

    if (finish) begin
      byte_in_word_next  = 2'd0;
      word_in_group_next = 2'd0;
      phase_next = (content_consumed_next < content_length) ? PH_SKIP : PH_CHUNK;
    end

    results.item.final_of_input = !end_of_file;

    if (end_of_file) begin
      results.report_valid          = 1'b1;
      results.report.final_of_input = 1'b1;
      if (hdr_seen_next < vcsp_pkg::MIN_FILE_BYTES) begin
        results.report.kind       = vcsp_pkg::KIND_ERROR;
        results.report.error_code = vcsp_pkg::ERR_TOO_SMALL;
      end else if (magic_failed_next) begin
        results.report.kind       = vcsp_pkg::KIND_ERROR;
        results.report.error_code = vcsp_pkg::ERR_BAD_MAGIC;
      end else if (main_failed_next) begin
        results.report.kind       = vcsp_pkg::KIND_ERROR;
        results.report.error_code = vcsp_pkg::ERR_MISSING_MAIN;
      end else begin
        results.report.kind         = vcsp_pkg::KIND_DONE;
        results.report.first_value  = size_words_next[0];
        results.report.second_value = size_words_next[1];
        results.report.third_value  = size_words_next[2];
        results.report.fourth_value = voxel_total_next;
      end
      // next byte starts a new file
      phase_next            = PH_HEADER;
      hdr_seen_next         = '0;
      magic_failed_next     = 1'b0;
      main_failed_next      = 1'b0;
      tag_shift_next        = '0;
      word_shift_next       = '0;
      byte_in_word_next     = '0;
      word_in_group_next    = '0;
      content_length_next   = '0;
      content_consumed_next = '0;
      voxels_left_next      = '0;
      palette_slot_next     = '0;
      voxel_total_next      = '0;
      size_words_next[0]    = '0;
      size_words_next[1]    = '0;
      size_words_next[2]    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      hdr_seen         <= '0;
      magic_failed     <= 1'b0;
      main_failed      <= 1'b0;
      tag_shift        <= '0;
      word_shift       <= '0;
      byte_in_word     <= '0;
      word_in_group    <= '0;
      content_length   <= '0;
      content_consumed <= '0;
      voxels_left      <= '0;
      palette_slot     <= '0;
      voxel_total      <= '0;
      size_words[0]    <= '0;
      size_words[1]    <= '0;
      size_words[2]    <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      hdr_seen         <= hdr_seen_next;
      magic_failed     <= magic_failed_next;
      main_failed      <= main_failed_next;
      tag_shift        <= tag_shift_next;
      word_shift       <= word_shift_next;
      byte_in_word     <= byte_in_word_next;
      word_in_group    <= word_in_group_next;
      content_length   <= content_length_next;
      content_consumed <= content_consumed_next;
      voxels_left      <= voxels_left_next;
      palette_slot     <= palette_slot_next;
      voxel_total      <= voxel_total_next;
      size_words       <= size_words_next;
    end
  end

endmodule

### hw/rtl/vcsp_result_queue.sv
`timescale 1ns / 1ps
// vcsp_result_queue: two-entry result register, head drives the output
// depends on vcsp_pkg

module vcsp_result_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  vcsp_pkg::parse_out_t results,
  output logic                 room,
  output logic                 head_valid,
  input  logic                 head_stall,
  output vcsp_pkg::result_t    head
);

  vcsp_pkg::result_t q0, q1;
  logic [1:0] count, count_next;
  logic       pop;
  logic [1:0] remain;

  assign pop        = head_valid && !head_stall;
  assign head_valid = (count != 2'd0);
  assign head       = q0;
  assign remain     = count - {1'b0, pop};
  // a byte may bring two results, so take one only into an emptied queue
  assign room       = (remain == 2'd0);

  always_comb begin
    count_next = remain;
    if (push) begin
      count_next = {1'b0, results.item_valid} + {1'b0, results.report_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (results.item_valid) begin
        q0 <= results.item;
        q1 <= results.report;
      end else begin
        q0 <= results.report;
      end
    end else if (pop && count == 2'd2) begin
      q0 <= q1;
    end
  end

endmodule

### hw/rtl/voxel_chunk_stream_parser_core.sv
`timescale 1ns / 1ps
// voxel_chunk_stream_parser_core: top level of the voxel file byte parser
// depends on vcsp_pkg, vcsp_parser, vcsp_result_queue
//
// usage
// - input channel (item_valid / item_stall): one file byte per transaction,
//   end_of_file high on the last byte of a file
// - result channel (result_valid / result_stall): voxels, palette entries,
//   then one done or error report per file; final_of_input marks the last
//   result caused by a byte
// - a byte updates the parse state on the edge that accepts it; its results
//   sit in a two-entry result register, the first on the ports the next cycle
// - throughput: one byte per cycle while the result side keeps up; a byte is
//   taken only when the result register will be empty after this cycle's
//   transaction, so after a last byte of a file that brings item plus report
//   the next byte waits until both results have left
// - when the receiver stalls, the head result holds and item_stall rises
//   as soon as a result is left waiting
// - reset clears the parse state to the start of a file and empties the
//   result register; after each end_of_file byte the parser returns to the
//   same state by itself

module voxel_chunk_stream_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_file,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [31:0] first_value,
  output logic [31:0] second_value,
  output logic [31:0] third_value,
  output logic [31:0] fourth_value,
  output logic [1:0]  error_code,
  output logic        final_of_input
);

  vcsp_pkg::parse_out_t results;
  vcsp_pkg::result_t    head;
  logic                 room;
  logic                 accept;

  assign item_stall = !room;
  assign accept     = item_valid && room;

  // parse state and per-byte result generation
  vcsp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .end_of_file (end_of_file),
    .results     (results)
  );

  // result register between parser and receiver
  vcsp_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .results    (results),
    .room       (room),
    .head_valid (result_valid),
    .head_stall (result_stall),
    .head       (head)
  );

  assign kind           = head.kind;
  assign first_value    = head.first_value;
  assign second_value   = head.second_value;
  assign third_value    = head.third_value;
  assign fourth_value   = head.fourth_value;
  assign error_code     = head.error_code;
  assign final_of_input = head.final_of_input;

endmodule

### hw/rtl/vcsp_checker.sv
`timescale 1ns / 1ps
// vcsp_checker: port-level assertions for the voxel chunk stream parser
// depends on vcsp_pkg; bound to voxel_chunk_stream_parser_core

module vcsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_stall,
  input logic [1:0]  kind,
  input logic [31:0] first_value,
  input logic [31:0] second_value,
  input logic [31:0] third_value,
  input logic [31:0] fourth_value,
  input logic [1:0]  error_code,
  input logic        final_of_input
);

  // a stalled result stays and holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(kind) &&
      $stable(first_value) && $stable(fourth_value) && $stable(final_of_input))
    else $error("stalled result changed");

  // reset empties the result register
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result shown right after reset");

  // a done or error report is always the last result of its byte
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind == vcsp_pkg::KIND_DONE || kind == vcsp_pkg::KIND_ERROR)
      |-> final_of_input)
    else $error("report not marked final");

  // error reports carry only a legal code
  assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == vcsp_pkg::KIND_ERROR |->
      first_value == '0 && second_value == '0 && third_value == '0 &&
      fourth_value == '0 && error_code != 2'd3)
    else $error("malformed error report");

  // voxel materials are raised to 1..255
  assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == vcsp_pkg::KIND_VOXEL |->
      fourth_value != '0 && fourth_value[31:8] == '0 && error_code == '0)
    else $error("voxel material out of range");

endmodule

bind voxel_chunk_stream_parser_core vcsp_checker u_vcsp_checker (
  .clk            (clk),
  .rst            (rst),
  .result_valid   (result_valid),
  .result_stall   (result_stall),
  .kind           (kind),
  .first_value    (first_value),
  .second_value   (second_value),
  .third_value    (third_value),
  .fourth_value   (fourth_value),
  .error_code     (error_code),
  .final_of_input (final_of_input)
);

### tb/tb_voxel_chunk_stream_parser_core.sv
`timescale 1ns / 1ps
// tb_voxel_chunk_stream_parser_core: self-checking bench for the voxel file byte parser
// depends on vcsp_pkg and voxel_chunk_stream_parser_core; typed rows and a byte-level
// predictor check every result: a directed table of files, then a run of random files

module tb_voxel_chunk_stream_parser_core;

  localparam int RUN_LIMIT     = 400000;
  localparam int PALETTE_SLOTS = 256;

  // chunk flavors for the file builder
  localparam int CH_SIZE  = 0;
  localparam int CH_XYZI  = 1;
  localparam int CH_RGBA  = 2;
  localparam int CH_OTHER = 3;

  typedef enum logic [2:0] {
    ST_HEADER, ST_CHUNK, ST_SIZE, ST_COUNT, ST_VOXEL, ST_RGBA, ST_SKIP, ST_HALT
  } parse_phase_e;

  // one row of the directed table: up to four bytes, low byte first
  typedef struct packed {
    logic [31:0]       word;
    logic [2:0]        nbytes;
    logic              eof;
    logic              typed;
    vcsp_pkg::result_t want;
  } stim_row_t;

  // one byte transaction waiting to be sent
  typedef struct packed {
    logic [7:0]        data;
    logic              eof;
    logic              typed;
    vcsp_pkg::result_t want;
  } feed_t;

  localparam vcsp_pkg::result_t NO_WANT = '0;
  localparam vcsp_pkg::result_t WANT_TOO_SMALL =
    '{vcsp_pkg::KIND_ERROR, 32'd0, 32'd0, 32'd0, 32'd0, vcsp_pkg::ERR_TOO_SMALL, 1'b1};
  localparam vcsp_pkg::result_t WANT_BAD_MAGIC =
    '{vcsp_pkg::KIND_ERROR, 32'd0, 32'd0, 32'd0, 32'd0, vcsp_pkg::ERR_BAD_MAGIC, 1'b1};
  localparam vcsp_pkg::result_t WANT_NO_MAIN =
    '{vcsp_pkg::KIND_ERROR, 32'd0, 32'd0, 32'd0, 32'd0, vcsp_pkg::ERR_MISSING_MAIN, 1'b1};
  localparam vcsp_pkg::result_t WANT_EMPTY_DONE =
    '{vcsp_pkg::KIND_DONE, 32'd0, 32'd0, 32'd0, 32'd0, vcsp_pkg::ERR_TOO_SMALL, 1'b1};

  // directed files; the expected result is typed in on error and trivial done rows,
  // every other row goes through the predictor
  localparam stim_row_t DIRECTED_ROWS [0:32] = '{
    // one-byte file, all ones
    '{32'h0000_00FF, 3'd1, 1'b1, 1'b1, WANT_TOO_SMALL},
    // short file with a wrong magic still reports too small
    '{32'h0000_0000, 3'd4, 1'b1, 1'b1, WANT_TOO_SMALL},
    // wrong magic, rest ignored to the last byte
    '{32'h2058_4F57, 3'd4, 1'b0, 1'b0, NO_WANT},
    '{32'h0000_0000, 3'd4, 1'b0, 1'b0, NO_WANT},
    '{32'hFFFF_FFFF, 3'd4, 1'b1, 1'b1, WANT_BAD_MAGIC},
    // good magic, wrong main tag
    '{vcsp_pkg::TAG_VOX,  3'd4, 1'b0, 1'b0, NO_WANT},
    '{32'h0000_0096,      3'd4, 1'b0, 1'b0, NO_WANT},
    '{32'h4E49_414E,      3'd4, 1'b1, 1'b1, WANT_NO_MAIN},
    // header cut short after main
    '{vcsp_pkg::TAG_VOX,  3'd4, 1'b0, 1'b0, NO_WANT},
    '{32'hFFFF_FFFF,      3'd4, 1'b0, 1'b0, NO_WANT},
    '{vcsp_pkg::TAG_MAIN, 3'd4, 1'b1, 1'b1, WANT_EMPTY_DONE},
    // full file: size, two voxels, palette cut off by the last byte
    '{vcsp_pkg::TAG_VOX,  3'd4, 1'b0, 1'b0, NO_WANT},
    '{32'h0000_0096,      3'd4, 1'b0, 1'b0, NO_WANT},
    '{vcsp_pkg::TAG_MAIN, 3'd4, 1'b0, 1'b0, NO_WANT},
    '{32'h0000_0000,      3'd4, 1'b0, 1'b0, NO_WANT},
    '{32'hFFFF_FFFF,      3'd4, 1'b0, 1'b0, NO_WANT},
    '{vcsp_pkg::TAG_SIZE, 3'd4, 1'b0, 1'b0, NO_WANT},
    '{32'd12,             3'd4, 1'b0, 1'b0, NO_WANT},
    '{32'd0,              3'd4, 1'b0, 1'b0, NO_WANT},
    '{32'hFFFF_FFFF,      3'd4, 1'b0, 1'b0, NO_WANT},
    '{32'h0000_0000,      3'd4, 1'b0, 1'b0, NO_WANT},
    '{32'h8000_0001,      3'd4, 1'b0, 1'b0, NO_WANT},
    '{vcsp_pkg::TAG_XYZI, 3'd4, 1'b0, 1'b0, NO_WANT},
    '{32'd12,             3'd4, 1'b0, 1'b0, NO_WANT},
    '{32'd0,              3'd4, 1'b0, 1'b0, NO_WANT},
    '{32'd2,              3'd4, 1'b0, 1'b0, NO_WANT},
    // material zero is raised to one
    '{32'h0003_0201,      3'd4, 1'b0, 1'b0, NO_WANT},
    '{32'hFFFF_FFFF,      3'd4, 1'b0, 1'b0, NO_WANT},
    '{vcsp_pkg::TAG_RGBA, 3'd4, 1'b0, 1'b0, NO_WANT},
    '{32'd1024,           3'd4, 1'b0, 1'b0, NO_WANT},
    '{32'd0,              3'd4, 1'b0, 1'b0, NO_WANT},
    '{32'hFFFF_FFFF,      3'd4, 1'b0, 1'b0, NO_WANT},
    // partial palette word on the last byte is dropped
    '{32'h0000_0012,      3'd1, 1'b1, 1'b0, NO_WANT}
  };

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic [7:0]  data_byte;
  logic        end_of_file;
  logic        result_valid;
  logic        result_stall;
  logic [1:0]  kind;
  logic [31:0] first_value;
  logic [31:0] second_value;
  logic [31:0] third_value;
  logic [31:0] fourth_value;
  logic [1:0]  error_code;
  logic        final_of_input;

  voxel_chunk_stream_parser_core uut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .data_byte      (data_byte),
    .end_of_file    (end_of_file),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .kind           (kind),
    .first_value    (first_value),
    .second_value   (second_value),
    .third_value    (third_value),
    .fourth_value   (fourth_value),
    .error_code     (error_code),
    .final_of_input (final_of_input)
  );

  // stimulus and expectation stores
  feed_t             byte_feed[$];
  feed_t             cur_item;
  vcsp_pkg::result_t byte_results[$];
  vcsp_pkg::result_t pending_results[$];
  bit                taken;
  int                fail_count  = 0;
  int                cycle_count = 0;

  // predictor state, one file at a time
  parse_phase_e phase;
  logic [4:0]   hdr_count;
  logic         magic_bad;
  logic         main_bad;
  logic [31:0]  tag_word;
  logic [31:0]  shift_word;
  logic [1:0]   byte_pos;
  logic [1:0]   word_pos;
  logic [31:0]  chunk_len;
  logic [31:0]  chunk_used;
  logic [31:0]  voxels_to_go;
  logic [8:0]   slot;
  logic [31:0]  voxel_count;
  logic [31:0]  dims [3];

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog: a hung handshake or a missing result ends here
  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    fail_count++;
  endtask

  function automatic void clear_parse_state();
    phase        = ST_HEADER;
    hdr_count    = '0;
    magic_bad    = 1'b0;
    main_bad     = 1'b0;
    tag_word     = '0;
    shift_word   = '0;
    byte_pos     = '0;
    word_pos     = '0;
    chunk_len    = '0;
    chunk_used   = '0;
    voxels_to_go = '0;
    slot         = '0;
    voxel_count  = '0;
    foreach (dims[i]) dims[i] = '0;
  endfunction

  // end of a chunk's items: skip what is left of its content, else next header
  function automatic void leave_items();
    byte_pos = '0;
    word_pos = '0;
    phase    = (chunk_used < chunk_len) ? ST_SKIP : ST_CHUNK;
  endfunction

  // advance the predictor by one byte; results land in byte_results
  task automatic predict_parse(input logic [7:0] b, input logic eof);
    logic              word_done;
    logic [31:0]       w;
    logic [7:0]        mat;
    vcsp_pkg::result_t r;
    word_done = 1'b0;
    if (hdr_count < vcsp_pkg::HEADER_BYTES) hdr_count = hdr_count + 5'd1;
    // words assemble little-endian, except while halted or skipping
    if (phase != ST_HALT && phase != ST_SKIP) begin
      shift_word = {b, shift_word[31:8]};
      byte_pos   = byte_pos + 2'd1;
      word_done  = (byte_pos == 2'd0);
    end
    // content counter saturates
    if (phase >= ST_SIZE && phase <= ST_SKIP && chunk_used != 32'hFFFF_FFFF)
      chunk_used = chunk_used + 32'd1;
    w = shift_word;

    case (phase)
      ST_HEADER: begin
        if (hdr_count == vcsp_pkg::MAGIC_END && w != vcsp_pkg::TAG_VOX) begin
          magic_bad = 1'b1;
          phase     = ST_HALT;
        end else if (hdr_count == vcsp_pkg::MAIN_END && w != vcsp_pkg::TAG_MAIN) begin
          main_bad = 1'b1;
          phase    = ST_HALT;
        end else if (hdr_count == vcsp_pkg::HEADER_BYTES) begin
          phase    = ST_CHUNK;
          byte_pos = '0;
          word_pos = '0;
        end
      end
      ST_CHUNK: if (word_done) begin
        if (word_pos == 2'd0) begin
          tag_word = w;
          word_pos = 2'd1;
        end else if (word_pos == 2'd1) begin
          chunk_len = w;
          word_pos  = 2'd2;
        end else begin
          // child length word: ignored, the chunk body starts here
          word_pos   = 2'd0;
          chunk_used = '0;
          if (tag_word == vcsp_pkg::TAG_SIZE) begin
            foreach (dims[i]) dims[i] = '0;
            phase = ST_SIZE;
          end else if (tag_word == vcsp_pkg::TAG_XYZI) begin
            phase = ST_COUNT;
          end else if (tag_word == vcsp_pkg::TAG_RGBA) begin
            slot  = '0;
            phase = ST_RGBA;
          end else begin
            phase = (chunk_len != 0) ? ST_SKIP : ST_CHUNK;
          end
        end
      end
      ST_SIZE: if (word_done) begin
        dims[(word_pos < 2'd3) ? word_pos : 2'd2] = w;
        if (word_pos >= 2'd2) leave_items();
        else word_pos = word_pos + 2'd1;
      end
      ST_COUNT: if (word_done) begin
        voxels_to_go = w;
        if (w == 0) leave_items();
        else phase = ST_VOXEL;
      end
      ST_VOXEL: if (word_done) begin
        mat = (w[31:24] == 8'd0) ? 8'd1 : w[31:24];
        r = '0;
        r.kind         = vcsp_pkg::KIND_VOXEL;
        r.first_value  = {24'd0, w[7:0]};
        r.second_value = {24'd0, w[15:8]};
        r.third_value  = {24'd0, w[23:16]};
        r.fourth_value = {24'd0, mat};
        byte_results.push_back(r);
        voxel_count  = voxel_count + 32'd1;
        voxels_to_go = voxels_to_go - 32'd1;
        if (voxels_to_go == 0) leave_items();
      end
      ST_RGBA: if (word_done) begin
        r = '0;
        r.kind         = vcsp_pkg::KIND_PALETTE;
        r.first_value  = {23'd0, slot};
        r.second_value = w;
        byte_results.push_back(r);
        slot = slot + 9'd1;
        if (slot >= PALETTE_SLOTS) leave_items();
      end
      ST_SKIP: begin
        if (chunk_used >= chunk_len) begin
          phase    = ST_CHUNK;
          byte_pos = '0;
          word_pos = '0;
        end
      end
      default: ;
    endcase

    // last byte of the file: one report, then back to a fresh file
    if (eof) begin
      r = '0;
      if (hdr_count < vcsp_pkg::MIN_FILE_BYTES) begin
        r.kind       = vcsp_pkg::KIND_ERROR;
        r.error_code = vcsp_pkg::ERR_TOO_SMALL;
      end else if (magic_bad) begin
        r.kind       = vcsp_pkg::KIND_ERROR;
        r.error_code = vcsp_pkg::ERR_BAD_MAGIC;
      end else if (main_bad) begin
        r.kind       = vcsp_pkg::KIND_ERROR;
        r.error_code = vcsp_pkg::ERR_MISSING_MAIN;
      end else begin
        r.kind         = vcsp_pkg::KIND_DONE;
        r.first_value  = dims[0];
        r.second_value = dims[1];
        r.third_value  = dims[2];
        r.fourth_value = voxel_count;
      end
      byte_results.push_back(r);
      clear_parse_state();
    end
    if (byte_results.size() != 0) begin
      r = byte_results.pop_back();
      r.final_of_input = 1'b1;
      byte_results.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // file builder
  // ---------------------------------------------------------------------------
  task automatic push_word(input logic [31:0] w, input int n);
    feed_t f;
    for (int k = 0; k < n; k++) begin
      f       = '0;
      f.data  = w[8*k +: 8];
      byte_feed.push_back(f);
    end
  endtask

  task automatic add_chunk(input int sel, input bit full_palette);
    int unsigned len;
    int unsigned used;
    int unsigned count;
    logic [31:0] w;
    used = 0;
    len  = 0;
    case (sel)
      CH_SIZE: begin
        // mostly the right length, sometimes short (still reads 12) or long (skip)
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : 12;
        push_word(vcsp_pkg::TAG_SIZE, 4);
        push_word(len, 4);
        push_word($urandom(), 4);
        repeat (3) push_word(($urandom_range(0, 1) == 0) ? $urandom_range(1, 256) : $urandom(), 4);
        used = 12;
      end
      CH_XYZI: begin
        count = $urandom_range(0, 4);
        len   = 4 + 4 * count;
        case ($urandom_range(0, 3))
          0: len = len + $urandom_range(1, 6);   // leftover content to skip
          1: len = $urandom_range(0, len);       // length at most what is read
          default: ;
        endcase
        push_word(vcsp_pkg::TAG_XYZI, 4);
        push_word(len, 4);
        push_word($urandom(), 4);
        // a huge count now and then makes the rest of the file voxels
        push_word(($urandom_range(0, 15) == 0) ? $urandom() : count, 4);
        repeat (count) begin
          w = $urandom();
          if ($urandom_range(0, 2) == 0) w[31:24] = 8'h00;
          push_word(w, 4);
        end
        used = 4 + 4 * count;
      end
      CH_RGBA: begin
        count = full_palette ? PALETTE_SLOTS : $urandom_range(0, 6);
        len   = full_palette ? 4 * PALETTE_SLOTS + $urandom_range(0, 5) : $urandom_range(0, 40);
        push_word(vcsp_pkg::TAG_RGBA, 4);
        push_word(len, 4);
        push_word($urandom(), 4);
        repeat (count) push_word($urandom(), 4);
        used = 4 * count;
      end
      default: begin
        // unknown tag, skipped whole
        len = $urandom_range(0, 10);
        push_word($urandom(), 4);
        push_word(len, 4);
        push_word($urandom(), 4);
      end
    endcase
    while (used < len) begin
      push_word($urandom(), 1);
      used++;
    end
  endtask

  task automatic add_random_file(input bit with_full_palette);
    int unsigned style;
    int unsigned start;
    int unsigned cut;
    logic [31:0] magic;
    logic [31:0] main_tag;
    feed_t       last;
    start = byte_feed.size();
    style = with_full_palette ? 2 : $urandom_range(0, 9);
    if (style == 0) begin
      // noise
      repeat ($urandom_range(1, 30)) push_word($urandom(), 1);
    end else begin
      magic    = vcsp_pkg::TAG_VOX;
      main_tag = vcsp_pkg::TAG_MAIN;
      if (style == 1) begin
        if ($urandom_range(0, 1) == 0) magic = magic ^ (32'd1 << $urandom_range(0, 31));
        else main_tag = main_tag ^ (32'd1 << $urandom_range(0, 31));
      end
      push_word(magic, 4);
      push_word($urandom(), 4);
      push_word(main_tag, 4);
      push_word($urandom(), 4);
      push_word($urandom(), 4);
      repeat ($urandom_range(0, 4)) add_chunk($urandom_range(CH_SIZE, CH_OTHER), 1'b0);
      if (with_full_palette) add_chunk(CH_RGBA, 1'b1);
    end
    // cut the file anywhere now and then
    if (!with_full_palette && $urandom_range(0, 3) == 0) begin
      cut = $urandom_range(start + 1, byte_feed.size());
      while (byte_feed.size() > cut) void'(byte_feed.pop_back());
    end
    last     = byte_feed.pop_back();
    last.eof = 1'b1;
    byte_feed.push_back(last);
  endtask

  // ---------------------------------------------------------------------------
  // input side: accept bytes and run the predictor
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) begin
      byte_results.delete();
      predict_parse(data_byte, end_of_file);
      // typed rows carry their own expectation; the predictor still tracks state
      if (cur_item.typed) pending_results.push_back(cur_item.want);
      else foreach (byte_results[i]) pending_results.push_back(byte_results[i]);
      taken = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // result side: compare each accepted transaction with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    vcsp_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected, kind", {30'd0, kind}, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (kind !== want.kind)
          report_mismatch("kind", {30'd0, kind}, {30'd0, want.kind});
        if (first_value !== want.first_value)
          report_mismatch("first_value", first_value, want.first_value);
        if (second_value !== want.second_value)
          report_mismatch("second_value", second_value, want.second_value);
        if (third_value !== want.third_value)
          report_mismatch("third_value", third_value, want.third_value);
        if (fourth_value !== want.fourth_value)
          report_mismatch("fourth_value", fourth_value, want.fourth_value);
        if (error_code !== want.error_code)
          report_mismatch("error_code", {30'd0, error_code}, {30'd0, want.error_code});
        if (final_of_input !== want.final_of_input)
          report_mismatch("final_of_input", {31'd0, final_of_input},
                          {31'd0, want.final_of_input});
      end
    end
  end

  // receiver stall pattern: modes switch every so often, including no stall at all
  int stall_mode = 0;
  int mode_left  = 0;
  int tick       = 0;
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    tick++;
    case (stall_mode)
      0: result_stall = 1'b0;
      1: result_stall = ($urandom_range(0, 3) == 0);
      2: result_stall = ($urandom_range(0, 1) == 0);
      default: result_stall = ((tick % 7) < 3);
    endcase
  end

  // ---------------------------------------------------------------------------
  // main sequence: reset, build stimulus, send in bursts, drain, verdict
  // ---------------------------------------------------------------------------
  initial begin
    int    base;
    int    burst_left;
    int    gap_left;
    bit    send_done;
    feed_t f;
    rst          = 1'b1;
    item_valid   = 1'b0;
    data_byte    = '0;
    end_of_file  = 1'b0;
    result_stall = 1'b0;
    taken        = 1'b0;
    cur_item     = '0;
    clear_parse_state();

    // directed table, one feed transaction per byte
    for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
      for (int k = 0; k < DIRECTED_ROWS[i].nbytes; k++) begin
        f       = '0;
        f.data  = DIRECTED_ROWS[i].word[8*k +: 8];
        if (k == DIRECTED_ROWS[i].nbytes - 1) begin
          f.eof   = DIRECTED_ROWS[i].eof;
          f.typed = DIRECTED_ROWS[i].typed;
          f.want  = DIRECTED_ROWS[i].want;
        end
        byte_feed.push_back(f);
      end
    end
    // random files, one of them with a complete palette
    base = byte_feed.size();
    while (byte_feed.size() - base < 450) add_random_file(1'b0);
    add_random_file(1'b1);
    repeat (3) add_random_file(1'b0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // sender: bursts of random length separated by random gaps
    burst_left = $urandom_range(1, 24);
    gap_left   = 0;
    send_done  = 1'b0;
    while (!send_done) begin
      @(negedge clk);
      // a stalled transaction holds its payload
      if (!item_valid || taken) begin
        taken = 1'b0;
        if (gap_left != 0) begin
          item_valid = 1'b0;
          gap_left--;
        end else if (byte_feed.size() == 0) begin
          item_valid = 1'b0;
          send_done  = 1'b1;
        end else begin
          cur_item    = byte_feed.pop_front();
          item_valid  = 1'b1;
          data_byte   = cur_item.data;
          end_of_file = cur_item.eof;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end

    // drain, then keep watching for anything unexpected
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

### files.f
hw/rtl/vcsp_pkg.sv
hw/rtl/vcsp_parser.sv
hw/rtl/vcsp_result_queue.sv
hw/rtl/voxel_chunk_stream_parser_core.sv
hw/rtl/vcsp_checker.sv
tb/tb_voxel_chunk_stream_parser_core.sv
